// ===== design/two_ended_segment_allocator_defines.svh =====
// Assertion macros for the two-ended segment allocator.
// Included by the RTL files that carry concurrent assertions; needs nothing else.
`ifndef TWO_ENDED_SEGMENT_ALLOCATOR_DEFINES_SVH
`define TWO_ENDED_SEGMENT_ALLOCATOR_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define TESA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment allocator assertion failed");

// Check that a condition implies another in the following cycle
`define TESA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment allocator assertion failed");

`endif

// ===== design/tesa_pkg.sv =====
// Shared widths, codes and types of the two-ended segment allocator.
// No dependencies; every file of the block but the defines header imports it.
`default_nettype none

package tesa_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int ADDR_BITS_DEF    = 24;

  localparam int FUNC_W     = 2;
  localparam int REQ_W      = 25;
  localparam int ADDR_W     = 24;
  localparam int LEN_W      = 25;
  localparam int SIZE_W     = 26;
  localparam int ALIGN_W    = 13;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 25;

  localparam logic [FUNC_W-1:0] FN_ALLOC_SYM  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ALLOC_ASYM = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FREE       = 2'd2;
  localparam logic [FUNC_W-1:0] FN_QUERY      = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_DESC   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP  = 4'd1;

  localparam logic [ALIGN_W-1:0] ALIGN_RESET = 13'd8;
  localparam logic [LEN_W-1:0]   HEAP_RESET  = 25'd16777216;

  typedef struct packed {
    logic               start;
    logic [REQ_W-1:0]   dividend;
    logic [ALIGN_W-1:0] divisor;
  } rem_ctl_t;

  typedef struct packed {
    logic               done;
    logic [ALIGN_W-1:0] rem;
  } rem_stat_t;

endpackage

`default_nettype wire

// ===== design/tesa_req_if.sv =====
// Request channel of the segment allocator: valid, ready and request fields.
// Depends on tesa_pkg for field widths.
`default_nettype none

interface tesa_req_if import tesa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [REQ_W-1:0]  req_size;
  logic [ADDR_W-1:0] address;

  modport source (output valid, func, req_size, address, input ready);
  modport sink (input valid, func, req_size, address, output ready);
endinterface

`default_nettype wire

// ===== design/tesa_rsp_if.sv =====
// Result channel of the segment allocator: valid, ready and result fields.
// Depends on tesa_pkg for field widths.
`default_nettype none

interface tesa_rsp_if import tesa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_address;
  logic [LEN_W-1:0]  result_size;
  logic [STAT_W-1:0] status;
  logic [LEN_W-1:0]  usage_now;
  logic [LEN_W-1:0]  usage_peak;

  modport source (output valid, result_address, result_size, status, usage_now, usage_peak,
                  input ready);
  modport sink (input valid, result_address, result_size, status, usage_now, usage_peak,
                output ready);
endinterface

`default_nettype wire

// ===== design/tesa_cfg_if.sv =====
// Configuration write channel of the segment allocator.
// Depends on tesa_pkg for index and data widths.
`default_nettype none

interface tesa_cfg_if import tesa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  waddr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, waddr, wdata, input ready);
  modport sink (input valid, waddr, wdata, output ready);
endinterface

`default_nettype wire

// ===== design/tesa_rem_unit.sv =====
// Bit-serial remainder unit: request size modulo alignment, one bit a cycle.
// Depends on tesa_pkg for rem_ctl_t and rem_stat_t.
`default_nettype none

module tesa_rem_unit import tesa_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  rem_ctl_t  ctl,
  output rem_stat_t stat
);

  localparam int CNT_W = $clog2(REQ_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [REQ_W-1:0]   shreg;
  logic [ALIGN_W-1:0] rem;
  logic [ALIGN_W-1:0] dvs;
  logic               done;
  logic [ALIGN_W:0]   trial;

  // shift in the next dividend bit and reduce once
  always_comb begin
    trial = {rem, shreg[REQ_W-1]};
    if (trial >= {1'b0, dvs}) begin
      trial = trial - {1'b0, dvs};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        shreg <= ctl.dividend;
        dvs   <= ctl.divisor;
        rem   <= '0;
        cnt   <= CNT_W'(REQ_W);
      end else if (busy) begin
        rem   <= trial[ALIGN_W-1:0];
        shreg <= {shreg[REQ_W-2:0], 1'b0};
        cnt   <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.rem  = rem;

endmodule

`default_nettype wire

// ===== design/two_ended_segment_allocator.sv =====
// Top level of the two-ended segment allocator: sequencer, descriptor memories.
// Depends on tesa_pkg, the three channel interfaces, tesa_rem_unit and the defines header.
//
//  channel | dir | transfer carries
//  req     | in  | func, req_size, address
//  rsp     | out | result_address, result_size, status, usage_now, usage_peak
//  cfg     | in  | waddr (0 align_bytes, 1 heap_bytes), wdata
//
// Allocate: rounding in S_DIV and S_RND and a walk over the descriptors; when a split is
//   needed, a search of up to MAX_SEGMENTS table entries, then writes in S_SPL1, S_SPL2.
// Free: a walk of up to 2*MAX_SEGMENTS descriptors both ways, then S_RLP, S_RLN, S_RLK.
// Query: a downward walk over the descriptors. The single read port sets the walk.
// Reset and heap_bytes writes rebuild descriptor 0 in S_INIT before requests.
// A finished result waits in the output register; the next request is taken meanwhile.
`default_nettype none
`include "two_ended_segment_allocator_defines.svh"

module two_ended_segment_allocator import tesa_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst,
  tesa_req_if.sink   req,
  tesa_rsp_if.source rsp,
  tesa_cfg_if.sink   cfg
);

  localparam int IXW  = $clog2(MAX_SEGMENTS);
  localparam int IW   = $clog2(MAX_SEGMENTS + 1);
  localparam int CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int AW   = ADDR_BITS;
  localparam int WW   = (AW > SIZE_W) ? AW : SIZE_W;
  localparam int CMPW = (AW > ADDR_W) ? AW : ADDR_W;
  localparam logic [IW-1:0] NIL = IW'(MAX_SEGMENTS);
  localparam logic [MAX_SEGMENTS-1:0] ONE_VALID = MAX_SEGMENTS'(1);
  localparam logic [LEN_W:0] HEAP_CAP = (ADDR_BITS >= LEN_W) ? {1'b0, {LEN_W{1'b1}}}
                                                            : ((LEN_W + 1)'(1) << ADDR_BITS);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_RND   = 4'd3;
  localparam logic [3:0] S_FIND  = 4'd4;
  localparam logic [3:0] S_FDSC  = 4'd5;
  localparam logic [3:0] S_SPL1  = 4'd6;
  localparam logic [3:0] S_SPL2  = 4'd7;
  localparam logic [3:0] S_FFULL = 4'd8;
  localparam logic [3:0] S_QRY   = 4'd9;
  localparam logic [3:0] S_RLP   = 4'd10;
  localparam logic [3:0] S_RLN   = 4'd11;
  localparam logic [3:0] S_RLK   = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  function automatic logic [LEN_W-1:0] cap_heap(input logic [LEN_W-1:0] v);
    return ({1'b0, v} > HEAP_CAP) ? HEAP_CAP[LEN_W-1:0] : v;
  endfunction

  // descriptor memories
  logic [AW-1:0]    mem_start [MAX_SEGMENTS];
  logic [LEN_W-1:0] mem_len   [MAX_SEGMENTS];
  logic [IW-1:0]    mem_prev  [MAX_SEGMENTS];
  logic [IW-1:0]    mem_next  [MAX_SEGMENTS];

  logic [IXW-1:0]   raddr;
  logic [AW-1:0]    rd_start;
  logic [LEN_W-1:0] rd_len;
  logic [IW-1:0]    rd_prev;
  logic [IW-1:0]    rd_next;

  logic             st_we, ln_we, pv_we, nx_we;
  logic [IXW-1:0]   st_wa, ln_wa, pv_wa, nx_wa;
  logic [AW-1:0]    st_wd;
  logic [LEN_W-1:0] ln_wd;
  logic [IW-1:0]    pv_wd, nx_wd;

  // control and working registers
  logic [3:0]              state;
  logic [MAX_SEGMENTS-1:0] valid_q;
  logic [MAX_SEGMENTS-1:0] full_q;
  logic [IW-1:0]           common_q;
  logic [LEN_W-1:0]        used_q;
  logic [LEN_W-1:0]        peak_q;
  logic [ALIGN_W-1:0]      align_q;
  logic [LEN_W-1:0]        heap_q;

  logic [FUNC_W-1:0] func_q;
  logic [REQ_W-1:0]  req_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SIZE_W-1:0] size_q;
  logic [IW-1:0]     cur_q;
  logic [CW-1:0]     cnt_q;
  logic [LEN_W-1:0]  best_q;
  logic              pass_q;
  logic [IW-1:0]     s_q;
  logic [AW-1:0]     s_start;
  logic [LEN_W-1:0]  s_len;
  logic [IW-1:0]     s_prev;
  logic [IW-1:0]     s_next;
  logic [IW-1:0]     d_q;
  logic [IW-1:0]     fd_q;

  logic [ADDR_W-1:0] res_addr;
  logic [LEN_W-1:0]  res_size;
  logic [STAT_W-1:0] res_stat;

  logic              o_valid;
  logic [ADDR_W-1:0] o_addr;
  logic [LEN_W-1:0]  o_size;
  logic [STAT_W-1:0] o_stat;
  logic [LEN_W-1:0]  o_now;
  logic [LEN_W-1:0]  o_peak;

  rem_ctl_t  rem_ctl;
  rem_stat_t rem_stat;

  logic [ALIGN_W-1:0] a_eff;
  logic               sym;
  logic               walk_end;
  logic [IW-1:0]      step_to;
  logic               pe, ne;
  logic [WW-1:0]      sym_sum, asym_sum;
  logic [LEN_W-1:0]   used_add;

  function automatic logic live(input logic [IW-1:0] i, input logic [MAX_SEGMENTS-1:0] v);
    return (i < NIL) && v[i[IXW-1:0]];
  endfunction

  tesa_rem_unit u_rem (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rem_ctl),
    .stat (rem_stat)
  );

  // derived values used by several states
  always_comb begin
    a_eff    = (align_q == '0) ? ALIGN_W'(1) : align_q;
    sym      = (func_q == FN_ALLOC_SYM);
    walk_end = (cnt_q == CW'(MAX_SEGMENTS)) || !live(cur_q, valid_q);
    pe       = live(s_prev, valid_q) && !full_q[s_prev[IXW-1:0]];
    ne       = live(s_next, valid_q) && !full_q[s_next[IXW-1:0]];
    sym_sum  = WW'(s_start) + WW'(size_q);
    asym_sum = WW'(s_start) + WW'(s_len) - WW'(size_q);
    used_add = used_q + size_q[LEN_W-1:0];
    if (state == S_FFULL) begin
      step_to = pass_q ? rd_next : rd_prev;
    end else if (state == S_QRY) begin
      step_to = rd_prev;
    end else begin
      step_to = sym ? rd_prev : rd_next;
    end
  end

  assign req.ready = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready = (state == S_IDLE);

  assign rem_ctl.start    = req.valid && req.ready && (req.func == FN_ALLOC_SYM ||
                                                       req.func == FN_ALLOC_ASYM);
  assign rem_ctl.dividend = req.req_size;
  assign rem_ctl.divisor  = a_eff;

  // read address and write ports of the descriptor memories
  always_comb begin
    raddr = common_q[IXW-1:0];
    st_we = 1'b0; ln_we = 1'b0; pv_we = 1'b0; nx_we = 1'b0;
    st_wa = s_q[IXW-1:0]; ln_wa = s_q[IXW-1:0];
    pv_wa = s_q[IXW-1:0]; nx_wa = s_q[IXW-1:0];
    st_wd = s_start; ln_wd = s_len; pv_wd = s_prev; nx_wd = s_next;
    unique case (state)
      S_INIT: begin
        st_we = 1'b1; ln_we = 1'b1; pv_we = 1'b1; nx_we = 1'b1;
        st_wa = '0; ln_wa = '0; pv_wa = '0; nx_wa = '0;
        st_wd = '0; ln_wd = heap_q; pv_wd = NIL; nx_wd = NIL;
      end
      S_FIND, S_QRY: begin
        raddr = step_to[IXW-1:0];
      end
      S_FFULL: begin
        if (!walk_end && full_q[cur_q[IXW-1:0]] && CMPW'(rd_start) == CMPW'(addr_q)) begin
          raddr = rd_prev[IXW-1:0];
        end else if (!walk_end) begin
          raddr = step_to[IXW-1:0];
        end
      end
      S_SPL1: begin
        st_we = 1'b1; ln_we = 1'b1; pv_we = 1'b1; nx_we = 1'b1;
        st_wa = d_q[IXW-1:0]; ln_wa = d_q[IXW-1:0];
        pv_wa = d_q[IXW-1:0]; nx_wa = d_q[IXW-1:0];
        st_wd = sym ? sym_sum[AW-1:0] : asym_sum[AW-1:0];
        ln_wd = sym ? (s_len - size_q[LEN_W-1:0]) : size_q[LEN_W-1:0];
        pv_wd = s_q;
        nx_wd = s_next;
      end
      S_SPL2: begin
        ln_we = 1'b1;
        ln_wd = sym ? size_q[LEN_W-1:0] : (s_len - size_q[LEN_W-1:0]);
        nx_we = 1'b1;
        nx_wd = d_q;
        pv_we = live(s_next, valid_q);
        pv_wa = s_next[IXW-1:0];
        pv_wd = d_q;
      end
      S_RLP: begin
        raddr = s_next[IXW-1:0];
        nx_we = pe && live(rd_prev, valid_q);
        nx_wa = rd_prev[IXW-1:0];
        nx_wd = s_q;
      end
      S_RLN: begin
        pv_we = ne && live(rd_next, valid_q);
        pv_wa = rd_next[IXW-1:0];
        pv_wd = s_q;
      end
      S_RLK: begin
        st_we = 1'b1; ln_we = 1'b1; pv_we = 1'b1; nx_we = 1'b1;
      end
      default: begin
        raddr = common_q[IXW-1:0];
      end
    endcase
  end

  // memory ports, read data registered
  always_ff @(posedge clk) begin
    if (st_we) mem_start[st_wa] <= st_wd;
    if (ln_we) mem_len[ln_wa]   <= ln_wd;
    if (pv_we) mem_prev[pv_wa]  <= pv_wd;
    if (nx_we) mem_next[nx_wa]  <= nx_wd;
    rd_start <= mem_start[raddr];
    rd_len   <= mem_len[raddr];
    rd_prev  <= mem_prev[raddr];
    rd_next  <= mem_next[raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      align_q  <= ALIGN_RESET;
      heap_q   <= cap_heap(HEAP_RESET);
      valid_q  <= ONE_VALID;
      full_q   <= '0;
      common_q <= '0;
      used_q   <= '0;
      peak_q   <= '0;
      o_valid  <= 1'b0;
    end else begin
      if (o_valid && rsp.ready) o_valid <= 1'b0;
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (cfg.valid) begin
            if (cfg.waddr == CFG_ALIGN) begin
              align_q <= cfg.wdata[ALIGN_W-1:0];
            end else if (cfg.waddr == CFG_HEAP) begin
              heap_q   <= cap_heap(cfg.wdata);
              valid_q  <= ONE_VALID;
              full_q   <= '0;
              common_q <= '0;
              used_q   <= '0;
              state    <= S_INIT;
            end
          end else if (req.valid) begin
            func_q   <= req.func;
            req_q    <= req.req_size;
            addr_q   <= req.address;
            res_addr <= '0;
            res_size <= '0;
            res_stat <= ST_OK;
            cur_q    <= common_q;
            cnt_q    <= '0;
            pass_q   <= 1'b0;
            best_q   <= '0;
            case (req.func)
              FN_FREE:  state <= S_FFULL;
              FN_QUERY: state <= S_QRY;
              default:  state <= S_DIV;
            endcase
          end
        end
        S_DIV: begin
          if (rem_stat.done) state <= S_RND;
        end
        S_RND: begin
          size_q <= (rem_stat.rem == '0) ? SIZE_W'(req_q)
                                         : SIZE_W'(req_q) + SIZE_W'(a_eff - rem_stat.rem);
          cur_q  <= common_q;
          cnt_q  <= '0;
          state  <= S_FIND;
        end
        S_FIND: begin
          if (walk_end) begin
            res_stat <= ST_NO_SPACE;
            state    <= S_DONE;
          end else if (!full_q[cur_q[IXW-1:0]] && SIZE_W'(rd_len) >= size_q) begin
            s_q     <= cur_q;
            s_start <= rd_start;
            s_len   <= rd_len;
            s_next  <= rd_next;
            if (cur_q != common_q && SIZE_W'(rd_len) == size_q) begin
              full_q[cur_q[IXW-1:0]] <= 1'b1;
              res_addr <= ADDR_W'(rd_start);
              res_size <= size_q[LEN_W-1:0];
              used_q   <= used_add;
              if (used_add > peak_q) peak_q <= used_add;
              state    <= S_DONE;
            end else begin
              fd_q  <= '0;
              state <= S_FDSC;
            end
          end else begin
            cur_q <= step_to;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_FDSC: begin
          if (!valid_q[fd_q[IXW-1:0]]) begin
            d_q   <= fd_q;
            state <= S_SPL1;
          end else if (fd_q == IW'(MAX_SEGMENTS - 1)) begin
            res_stat <= ST_NO_DESC;
            state    <= S_DONE;
          end else begin
            fd_q <= fd_q + 1'b1;
          end
        end
        S_SPL1: begin
          valid_q[d_q[IXW-1:0]] <= 1'b1;
          full_q[d_q[IXW-1:0]]  <= !sym;
          state <= S_SPL2;
        end
        S_SPL2: begin
          if (sym) begin
            full_q[s_q[IXW-1:0]] <= 1'b1;
            if (common_q == s_q) common_q <= d_q;
          end
          res_addr <= sym ? ADDR_W'(s_start) : ADDR_W'(asym_sum[AW-1:0]);
          res_size <= size_q[LEN_W-1:0];
          used_q   <= used_add;
          if (used_add > peak_q) peak_q <= used_add;
          state    <= S_DONE;
        end
        S_FFULL: begin
          if (walk_end) begin
            if (!pass_q) begin
              pass_q <= 1'b1;
              cur_q  <= common_q;
              cnt_q  <= '0;
            end else begin
              res_stat <= ST_NOT_FOUND;
              state    <= S_DONE;
            end
          end else if (full_q[cur_q[IXW-1:0]] && CMPW'(rd_start) == CMPW'(addr_q)) begin
            s_q      <= cur_q;
            s_start  <= rd_start;
            s_len    <= rd_len;
            s_prev   <= rd_prev;
            s_next   <= rd_next;
            res_size <= rd_len;
            used_q   <= (used_q >= rd_len) ? used_q - rd_len : '0;
            state    <= S_RLP;
          end else begin
            cur_q <= step_to;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_RLP: begin
          // merge the empty lower neighbor
          if (pe) begin
            s_start <= rd_start;
            s_len   <= s_len + rd_len;
            s_prev  <= rd_prev;
            if (common_q == s_prev) common_q <= s_q;
            valid_q[s_prev[IXW-1:0]] <= 1'b0;
          end
          state <= S_RLN;
        end
        S_RLN: begin
          // merge the empty upper neighbor
          if (ne) begin
            s_len  <= s_len + rd_len;
            s_next <= rd_next;
            if (common_q == s_next) common_q <= s_q;
            valid_q[s_next[IXW-1:0]] <= 1'b0;
          end
          state <= S_RLK;
        end
        S_RLK: begin
          full_q[s_q[IXW-1:0]] <= 1'b0;
          state <= S_DONE;
        end
        S_QRY: begin
          if (walk_end || best_q >= req_q) begin
            res_size <= (best_q > req_q) ? req_q : best_q;
            state    <= S_DONE;
          end else begin
            if (!full_q[cur_q[IXW-1:0]] && rd_len > best_q) best_q <= rd_len;
            cur_q <= step_to;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DONE: begin
          if (!o_valid || rsp.ready) begin
            o_valid <= 1'b1;
            o_addr  <= res_addr;
            o_size  <= res_size;
            o_stat  <= res_stat;
            o_now   <= used_q;
            o_peak  <= peak_q;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.result_address = o_addr;
  assign rsp.result_size    = o_size;
  assign rsp.status         = o_stat;
  assign rsp.usage_now      = o_now;
  assign rsp.usage_peak     = o_peak;

  `TESA_ASSERT_IMP(a_common_live, clk, rst, state == S_IDLE, valid_q[common_q[IXW-1:0]])
  `TESA_ASSERT_IMP(a_peak_bound, clk, rst, 1'b1, used_q <= peak_q)
  `TESA_ASSERT_NXT(a_busy_after_take, clk, rst, req.valid && req.ready, !req.ready)

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for two_ended_segment_allocator: random and directed requests,
// checked against an in-bench descriptor-table predictor. Depends on tesa_pkg and the
// tesa_req_if, tesa_rsp_if and tesa_cfg_if interfaces.
`default_nettype none

module tb_top;
  import tesa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEG      = 64;
  localparam int NIL       = NSEG;
  localparam longint unsigned HEAP_CAP = 64'd1 << 24;
  localparam int HOLD_LEN  = 400;
  localparam int DOG_LIMIT = 4000;
  localparam int DRAIN_CYC = 200;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [REQ_W-1:0]  req_size;
    logic [ADDR_W-1:0] address;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [LEN_W-1:0]  result_size;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  usage_now;
    logic [LEN_W-1:0]  usage_peak;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tesa_req_if req ();
  tesa_rsp_if rsp ();
  tesa_cfg_if cfg ();

  two_ended_segment_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the allocator state
  longint unsigned align_now, heap_now, used_now, peak_now;
  longint unsigned d_start[NSEG], d_len[NSEG];
  bit d_full[NSEG], d_valid[NSEG];
  int unsigned d_prev[NSEG], d_next[NSEG];
  int unsigned common_seg;

  request_t          pending_q[$];
  outcome_t          outcome_q[$];
  logic [ADDR_W-1:0] granted_q[$];
  int errors = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int transfers = 0;

  function automatic bit seg_live(int unsigned i);
    return i < NSEG && d_valid[i];
  endfunction

  function automatic void rebuild_table();
    for (int i = 0; i < NSEG; i++) begin
      d_start[i] = 0; d_len[i] = 0; d_full[i] = 0; d_valid[i] = 0;
      d_prev[i] = NIL; d_next[i] = NIL;
    end
    d_valid[0] = 1;
    d_len[0] = heap_now;
    common_seg = 0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_ALIGN) begin
      align_now = val[ALIGN_W-1:0];
    end else if (idx == CFG_HEAP) begin
      heap_now = val;
      if (heap_now > HEAP_CAP) heap_now = HEAP_CAP;
      rebuild_table();
      used_now = 0;
    end
  endfunction

  function automatic int unsigned first_unused();
    for (int i = 0; i < NSEG; i++)
      if (!d_valid[i]) return i;
    return NIL;
  endfunction

  function automatic int unsigned find_hole(longint unsigned size, bit down);
    int unsigned cur;
    cur = common_seg;
    for (int n = 0; n < NSEG && seg_live(cur); n++) begin
      if (!d_full[cur] && d_len[cur] >= size) return cur;
      cur = down ? d_prev[cur] : d_next[cur];
    end
    return NIL;
  endfunction

  function automatic int unsigned find_block(logic [ADDR_W-1:0] addr, bit down);
    int unsigned cur;
    cur = common_seg;
    for (int n = 0; n < NSEG && seg_live(cur); n++) begin
      if (d_full[cur] && (d_start[cur] & (HEAP_CAP - 1)) == addr) return cur;
      cur = down ? d_prev[cur] : d_next[cur];
    end
    return NIL;
  endfunction

  function automatic void insert_after(int unsigned s, int unsigned d);
    int unsigned nx;
    nx = d_next[s];
    d_valid[d] = 1;
    d_prev[d] = s;
    d_next[d] = nx;
    if (seg_live(nx)) d_prev[nx] = d;
    d_next[s] = d;
  endfunction

  function automatic void retire(int unsigned i);
    d_valid[i] = 0; d_full[i] = 0; d_start[i] = 0; d_len[i] = 0;
    d_prev[i] = NIL; d_next[i] = NIL;
  endfunction

  // Empty the segment and merge it with empty neighbors
  function automatic void coalesce(int unsigned k);
    int unsigned p, n, pp, nn;
    bit pe, ne;
    p = d_prev[k];
    n = d_next[k];
    pe = seg_live(p) && !d_full[p];
    ne = seg_live(n) && !d_full[n];
    d_full[k] = 0;
    if (pe) begin
      pp = d_prev[p];
      d_start[k] = d_start[p];
      d_len[k] += d_len[p];
      d_prev[k] = pp;
      if (seg_live(pp)) d_next[pp] = k;
      if (common_seg == p) common_seg = k;
      retire(p);
    end
    if (ne) begin
      nn = d_next[n];
      d_len[k] += d_len[n];
      d_next[k] = nn;
      if (seg_live(nn)) d_prev[nn] = k;
      if (common_seg == n) common_seg = k;
      retire(n);
    end
  endfunction

  function automatic outcome_t serve_request(request_t r);
    outcome_t o;
    longint unsigned a, size, best, raddr, rsize;
    logic [STAT_W-1:0] st;
    int unsigned s, d, k, cur;
    bit down;
    raddr = 0; rsize = 0; st = ST_OK;
    if (r.func == FN_ALLOC_SYM || r.func == FN_ALLOC_ASYM) begin
      down = (r.func == FN_ALLOC_SYM);
      a = (align_now != 0) ? align_now : 1;
      size = r.req_size;
      if (size % a != 0) size = (size / a + 1) * a;
      s = find_hole(size, down);
      if (s == NIL) begin
        st = ST_NO_SPACE;
      end else if (s != common_seg && d_len[s] == size) begin
        d_full[s] = 1;
        raddr = d_start[s];
      end else begin
        d = first_unused();
        if (d == NIL) begin
          st = ST_NO_DESC;
        end else if (down) begin
          insert_after(s, d);
          d_start[d] = d_start[s] + size;
          d_len[d] = d_len[s] - size;
          d_full[d] = 0;
          d_len[s] = size;
          d_full[s] = 1;
          if (common_seg == s) common_seg = d;
          raddr = d_start[s];
        end else begin
          insert_after(s, d);
          d_start[d] = d_start[s] + d_len[s] - size;
          d_len[d] = size;
          d_full[d] = 1;
          d_len[s] -= size;
          raddr = d_start[d];
        end
      end
      if (st == ST_OK) begin
        rsize = size;
        used_now += size;
        if (used_now > peak_now) peak_now = used_now;
        granted_q.push_back(raddr[ADDR_W-1:0]);
      end else begin
        raddr = 0;
      end
    end else if (r.func == FN_FREE) begin
      k = find_block(r.address, 1'b1);
      if (k == NIL) k = find_block(r.address, 1'b0);
      if (k == NIL) begin
        st = ST_NOT_FOUND;
      end else begin
        rsize = d_len[k];
        used_now = (used_now >= rsize) ? used_now - rsize : 0;
        coalesce(k);
      end
    end else begin
      cur = common_seg;
      best = 0;
      for (int n = 0; n < NSEG && seg_live(cur) && best < r.req_size; n++) begin
        if (!d_full[cur] && d_len[cur] > best) best = d_len[cur];
        cur = d_prev[cur];
      end
      rsize = (best > r.req_size) ? r.req_size : best;
    end
    o.result_address = raddr[ADDR_W-1:0];
    o.result_size    = rsize[LEN_W-1:0];
    o.status         = st;
    o.usage_now      = used_now[LEN_W-1:0];
    o.usage_peak     = peak_now[LEN_W-1:0];
    return o;
  endfunction

  // Request driver: pop pending items, hold each until its transfer
  int req_gap = 0;
  always @(posedge clk) begin
    request_t item;
    logic nv;
    if (rst) begin
      req.valid <= 1'b0;
      req.func <= FN_QUERY;
      req.req_size <= '0;
      req.address <= '0;
    end else begin
      nv = req.valid;
      if (req.valid && req.ready) begin
        item.func = req.func;
        item.req_size = req.req_size;
        item.address = req.address;
        outcome_q.push_back(serve_request(item));
        nv = 1'b0;
      end
      if (!nv) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pending_q.size() > 0) begin
          item = pending_q.pop_front();
          req.func <= item.func;
          req.req_size <= item.req_size;
          req.address <= item.address;
          nv = 1'b1;
          req_gap = idle_on ? $urandom_range(0, 11) : 0;
        end
      end
      req.valid <= nv;
    end
  end

  // Result monitor: compare each transfer with the oldest expectation
  int rsp_stall = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    outcome_t exp_o;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          exp_o = outcome_q.pop_front();
          if (rsp.result_address !== exp_o.result_address) begin
            $error("result_address exp %0h got %0h", exp_o.result_address, rsp.result_address);
            errors++;
          end
          if (rsp.result_size !== exp_o.result_size) begin
            $error("result_size exp %0d got %0d", exp_o.result_size, rsp.result_size);
            errors++;
          end
          if (rsp.status !== exp_o.status) begin
            $error("status exp %0d got %0d", exp_o.status, rsp.status);
            errors++;
          end
          if (rsp.usage_now !== exp_o.usage_now) begin
            $error("usage_now exp %0d got %0d", exp_o.usage_now, rsp.usage_now);
            errors++;
          end
          if (rsp.usage_peak !== exp_o.usage_peak) begin
            $error("usage_peak exp %0d got %0d", exp_o.usage_peak, rsp.usage_peak);
            errors++;
          end
        end
        rsp_stall = idle_on ? $urandom_range(0, 11) : 0;
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
        rsp_stall--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet <= 0;
    end else if (quiet >= DOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg.waddr <= idx;
    cfg.wdata <= val;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    apply_register(idx, val);
    cfg.valid <= 1'b0;
  endtask

  task automatic push_req(logic [FUNC_W-1:0] f, logic [REQ_W-1:0] sz, logic [ADDR_W-1:0] ad);
    request_t r;
    r.func = f;
    r.req_size = sz;
    r.address = ad;
    pending_q.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || req.valid || outcome_q.size() > 0) @(posedge clk);
  endtask

  function automatic logic [REQ_W-1:0] pick_size(longint unsigned last_freed);
    int c;
    c = $urandom_range(0, 9);
    if (c == 0) return $urandom_range(0, 33554431);
    if (c == 1) return 0;
    if (c == 2) return last_freed;
    return $urandom_range(0, heap_now / 6 + 1);
  endfunction

  // Fill a batch of random requests, mostly allocate/free pairs on live blocks
  task automatic random_batch(int count);
    int c, idx;
    logic [ADDR_W-1:0] ad;
    longint unsigned last_freed;
    last_freed = align_now;
    for (int i = 0; i < count; i++) begin
      c = $urandom_range(0, 99);
      if (c < 40) begin
        push_req(c < 20 ? FN_ALLOC_SYM : FN_ALLOC_ASYM, pick_size(last_freed),
                 $urandom_range(0, 16777215));
      end else if (c < 75 && granted_q.size() > 0) begin
        idx = $urandom_range(0, granted_q.size() - 1);
        ad = granted_q[idx];
        granted_q.delete(idx);
        push_req(FN_FREE, $urandom_range(0, 33554431), ad);
      end else if (c < 85) begin
        push_req(FN_FREE, $urandom_range(0, 33554431), $urandom_range(0, 16777215));
      end else begin
        push_req(FN_QUERY, (c < 88) ? $urandom_range(0, 33554431) : pick_size(last_freed),
                 $urandom_range(0, 16777215));
      end
      if (c % 7 == 0) last_freed = pick_size(align_now);
    end
  endtask

  task automatic run_phase(int items);
    int done;
    done = 0;
    while (done < items) begin
      idle_on = ($urandom_range(0, 4) != 0);
      random_batch(16);
      done += 16;
      wait_drained();
    end
  endtask

  initial begin
    cfg.valid = 1'b0;
    cfg.waddr = CFG_ALIGN;
    cfg.wdata = '0;
    align_now = ALIGN_RESET;
    heap_now = HEAP_RESET;
    used_now = 0;
    peak_now = 0;
    rebuild_table();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes and each function at reset settings
    push_req(FN_ALLOC_SYM, 0, 0);
    push_req(FN_ALLOC_SYM, 1, 24'hFFFFFF);
    push_req(FN_ALLOC_ASYM, 100, 0);
    push_req(FN_ALLOC_SYM, 25'h1FFFFFF, 0);
    push_req(FN_ALLOC_ASYM, 25'd16777216, 0);
    push_req(FN_QUERY, 0, 0);
    push_req(FN_QUERY, 25'h1FFFFFF, 24'hFFFFFF);
    push_req(FN_QUERY, 5, 0);
    push_req(FN_FREE, 0, 24'hFFFFFF);
    push_req(FN_FREE, 0, 0);
    push_req(FN_FREE, 25'h1FFFFFF, 0);
    wait_drained();
    while (granted_q.size() > 0) push_req(FN_FREE, 0, granted_q.pop_front());
    wait_drained();

    // Fill the output side while the receiver holds off
    hold_req = 1'b1;
    run_phase(32);
    run_phase(128);

    // Small heap, unit alignment; exhausts the common segment and descriptors
    repeat (DRAIN_CYC) @(posedge clk);
    write_register(CFG_ALIGN, 1);
    write_register(CFG_HEAP, 1000);
    granted_q.delete();
    push_req(FN_ALLOC_SYM, 1000, 0);
    push_req(FN_ALLOC_ASYM, 0, 0);
    push_req(FN_QUERY, 1000, 0);
    wait_drained();
    run_phase(160);

    repeat (DRAIN_CYC) @(posedge clk);
    write_register(CFG_ALIGN, 4096);
    write_register(CFG_HEAP, 25'd16777216);
    granted_q.delete();
    run_phase(160);

    // Zero alignment acts as one; tiny heap
    repeat (DRAIN_CYC) @(posedge clk);
    write_register(CFG_ALIGN, 0);
    write_register(CFG_HEAP, 300);
    granted_q.delete();
    run_phase(160);

    // Empty heap and widest alignment code
    repeat (DRAIN_CYC) @(posedge clk);
    write_register(CFG_ALIGN, 13'h1FFF);
    write_register(CFG_HEAP, 0);
    granted_q.delete();
    run_phase(48);

    // Oversized heap value is capped
    repeat (DRAIN_CYC) @(posedge clk);
    write_register(CFG_ALIGN, 16);
    write_register(CFG_HEAP, 25'h1FFFFFF);
    granted_q.delete();
    run_phase(160);

    repeat (DRAIN_CYC) @(posedge clk);
    write_register(CFG_ALIGN, 3);
    write_register(CFG_HEAP, 5000);
    granted_q.delete();
    hold_req = 1'b1;
    run_phase(160);

    repeat (DRAIN_CYC) @(posedge clk);
    write_register(CFG_ALIGN, 64);
    write_register(CFG_HEAP, 20000);
    granted_q.delete();
    run_phase(144);

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
